// ----- sv/rtcp_pkg.sv -----
// Shared types and constants for the serial RTC command parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rtcp_pkg;

   // Result codes.
   localparam logic [2:0] EV_READ     = 3'd0;
   localparam logic [2:0] EV_SET      = 3'd1;
   localparam logic [2:0] EV_USAGE    = 3'd2;
   localparam logic [2:0] EV_UNKNOWN  = 3'd3;
   localparam logic [2:0] EV_TOO_LONG = 3'd4;

   // Field widths.
   localparam int KIND_W = 3;
   localparam int YEAR_W = 14;
   localparam int FLD_W  = 7;
   localparam int POS_W  = 5;

   // Bits of the match flag vector.
   localparam int FLAG_GET = 0;
   localparam int FLAG_SET = 1;
   localparam int FLAG_PAY = 2;

   // Match position codes.
   localparam logic [POS_W-1:0] POS_SPACES  = 5'd7;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd8;
   localparam logic [POS_W-1:0] POS_END     = 5'd27;
   localparam logic [POS_W-1:0] POS_OVER    = 5'd28;

   // Characters.
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Command words; index 0 holds the first character.
   localparam logic [6:0][7:0] WORD_GET = {8'h74, 8'h65, 8'h67, 8'h20, 8'h63, 8'h74, 8'h72};
   localparam logic [6:0][7:0] WORD_SET = {8'h74, 8'h65, 8'h73, 8'h20, 8'h63, 8'h74, 8'h72};

   // Queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One classified byte.
   typedef struct packed {
      logic [7:0] ch;
      logic       is_term;
      logic       is_zero;
      logic       is_space;
      logic       is_dash;
      logic       is_colon;
      logic       is_t;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

endpackage

`default_nettype wire

// ----- sv/serial_rtc_command_parser.sv -----
// Serial RTC command parser. One received byte is accepted per clock cycle for
// as long as the result side keeps up. Each byte is classified on entry and
// placed in a four-entry queue; the parser takes one byte from the queue per
// cycle, unless a terminator waits for the output register, and updates its
// line state, so one byte per cycle is the sustained rate. A CR or LF ending a
// non-empty line yields one result transaction. With the queue empty and the
// output register free, the terminator passes through the queue register and
// then loads the output register, which drives rsp_valid. While a result waits
// in the output register, the queue keeps absorbing bytes until it is full; a
// terminator ending a non-empty line waits in the queue until the output
// register is free. Depends on rtcp_pkg, rtcp_front, rtcp_queue and rtcp_back.
`default_nettype none

module serial_rtc_command_parser #(
   parameter int LINE_BUFFER_SIZE = 96
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [rtcp_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [rtcp_pkg::YEAR_W-1:0]          rsp_year,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_month,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_day,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_hour,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_minute,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_second
);
   import rtcp_pkg::*;

   logic     queue_full;
   logic     push_valid;
   item_type push_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   rtcp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   rtcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   rtcp_back #(
      .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_year       (rsp_year),
      .rsp_month      (rsp_month),
      .rsp_day        (rsp_day),
      .rsp_hour       (rsp_hour),
      .rsp_minute     (rsp_minute),
      .rsp_second     (rsp_second)
   );

endmodule

`default_nettype wire

// ----- sv/rtcp_front.sv -----
// Front end: accepts received bytes and classifies each one.
// Depends on rtcp_pkg; feeds rtcp_queue.
`default_nettype none

module rtcp_front (
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                queue_full,
   output logic                     push_valid,
   output rtcp_pkg::item_type       push_item
);
   import rtcp_pkg::*;

   logic [7:0] sub_zero;

   assign sub_zero   = req_rx_byte - CH_ZERO;
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_item          = '0;
      push_item.ch       = req_rx_byte;
      push_item.is_term  = (req_rx_byte == CH_CR) || (req_rx_byte == CH_LF);
      push_item.is_zero  = (req_rx_byte == CH_NUL);
      push_item.is_space = (req_rx_byte == CH_SPACE);
      push_item.is_dash  = (req_rx_byte == CH_DASH);
      push_item.is_colon = (req_rx_byte == CH_COLON);
      push_item.is_t     = (req_rx_byte == CH_T);
      push_item.is_digit = (req_rx_byte >= CH_ZERO) && (req_rx_byte <= CH_NINE);
      push_item.digit    = push_item.is_digit ? sub_zero[3:0] : 4'd0;
   end

endmodule

`default_nettype wire

// ----- sv/rtcp_queue.sv -----
// Short queue of classified bytes between the front end and the parser.
// Depends on rtcp_pkg for the item type and the queue depth.
`default_nettype none

module rtcp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire rtcp_pkg::item_type  push_item,
   output logic                     full,
   output logic                     head_valid,
   output rtcp_pkg::item_type       head_item,
   input  wire logic                pop
);
   import rtcp_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_valid) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtcp_back.sv -----
// Back end: line state, prefix matcher, timestamp digit accumulators and the
// result register. Depends on rtcp_pkg; consumes items from rtcp_queue.
`default_nettype none

module rtcp_back #(
   parameter int LINE_BUFFER_SIZE = 96
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            head_valid,
   input  wire rtcp_pkg::item_type              head_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [rtcp_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [rtcp_pkg::YEAR_W-1:0]          rsp_year,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_month,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_day,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_hour,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_minute,
   output logic [rtcp_pkg::FLD_W-1:0]           rsp_second
);
   import rtcp_pkg::*;

   localparam int LC_W = $clog2(LINE_BUFFER_SIZE);
   localparam logic [LC_W-1:0] LINE_LIMIT = LC_W'(LINE_BUFFER_SIZE - 1);

   logic [LC_W-1:0]   count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              ended_ff, ended_in;
   logic              lead_ff, lead_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [2:0]        flags_ff, flags_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [FLD_W-1:0]  month_ff, month_in;
   logic [FLD_W-1:0]  day_ff, day_in;
   logic [FLD_W-1:0]  hour_ff, hour_in;
   logic [FLD_W-1:0]  minute_ff, minute_in;
   logic [FLD_W-1:0]  second_ff, second_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [YEAR_W-1:0] out_year_ff, out_year_in;
   logic [FLD_W-1:0]  out_month_ff, out_month_in;
   logic [FLD_W-1:0]  out_day_ff, out_day_in;
   logic [FLD_W-1:0]  out_hour_ff, out_hour_in;
   logic [FLD_W-1:0]  out_minute_ff, out_minute_in;
   logic [FLD_W-1:0]  out_second_ff, out_second_in;

   logic              out_free;
   logic              has_result;
   logic              load;
   logic              text_end;
   logic [POS_W-1:0]  pos_eff;
   logic [POS_W-1:0]  q;
   logic [KIND_W-1:0] kind;
   logic [3:0]        d;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign has_result = ovf_ff || (count_ff != '0);
   assign text_end   = ended_ff || head_item.is_zero;
   assign pos_eff    = (pos_ff == POS_SPACES) ? POS_PAYLOAD : pos_ff;
   assign q          = pos_eff - POS_PAYLOAD;
   assign d          = head_item.digit;

   // Classification of the finished line, from the state before the terminator.
   always_comb begin
      if (ovf_ff) begin
         kind = EV_TOO_LONG;
      end else if (pos_ff == POS_SPACES && flags_ff[FLAG_GET]) begin
         kind = EV_READ;
      end else if (pos_ff >= POS_SPACES && flags_ff[FLAG_SET]) begin
         kind = (flags_ff[FLAG_PAY] && pos_ff == POS_END) ? EV_SET : EV_USAGE;
      end else begin
         kind = EV_UNKNOWN;
      end
   end

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      ended_in  = ended_ff;
      lead_in   = lead_ff;
      pos_in    = pos_ff;
      flags_in  = flags_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      pop       = 1'b0;
      load      = 1'b0;

      if (head_valid) begin
         if (head_item.is_term) begin
            // A terminator that gives a result waits for room in the output register.
            if (!has_result || out_free) begin
               pop       = 1'b1;
               load      = has_result;
               count_in  = '0;
               ovf_in    = 1'b0;
               ended_in  = 1'b0;
               lead_in   = 1'b1;
               pos_in    = '0;
               flags_in  = 3'b111;
               year_in   = '0;
               month_in  = '0;
               day_in    = '0;
               hour_in   = '0;
               minute_in = '0;
               second_in = '0;
            end
         end else begin
            pop = 1'b1;
            if (count_ff < LINE_LIMIT) begin
               count_in = count_ff + 1'b1;
               ended_in = text_end;
               if (!text_end && !(lead_ff && head_item.is_space)) begin
                  lead_in = 1'b0;
                  if (pos_ff < POS_SPACES) begin
                     if (head_item.ch != WORD_GET[pos_ff[2:0]]) flags_in[FLAG_GET] = 1'b0;
                     if (head_item.ch != WORD_SET[pos_ff[2:0]]) flags_in[FLAG_SET] = 1'b0;
                     pos_in = pos_ff + 1'b1;
                  end else begin
                     flags_in[FLAG_GET] = 1'b0;
                     // Spaces between the prefix and the timestamp are skipped.
                     if (flags_ff[FLAG_SET] &&
                         !(pos_ff == POS_SPACES && head_item.is_space)) begin
                        if (pos_eff >= POS_END) begin
                           flags_in[FLAG_PAY] = 1'b0;
                           pos_in = POS_OVER;
                        end else begin
                           pos_in = pos_eff + 1'b1;
                           if (q == 5'd4 || q == 5'd7) begin
                              if (!head_item.is_dash) flags_in[FLAG_PAY] = 1'b0;
                           end else if (q == 5'd10) begin
                              if (!head_item.is_space && !head_item.is_t) begin
                                 flags_in[FLAG_PAY] = 1'b0;
                              end
                           end else if (q == 5'd13 || q == 5'd16) begin
                              if (!head_item.is_colon) flags_in[FLAG_PAY] = 1'b0;
                           end else if (!head_item.is_digit) begin
                              flags_in[FLAG_PAY] = 1'b0;
                           end else if (q < 5'd4) begin
                              year_in = YEAR_W'({year_ff, 3'b000} + {year_ff, 1'b0} + d);
                           end else if (q < 5'd7) begin
                              month_in = FLD_W'({month_ff, 3'b000} + {month_ff, 1'b0} + d);
                           end else if (q < 5'd10) begin
                              day_in = FLD_W'({day_ff, 3'b000} + {day_ff, 1'b0} + d);
                           end else if (q < 5'd13) begin
                              hour_in = FLD_W'({hour_ff, 3'b000} + {hour_ff, 1'b0} + d);
                           end else if (q < 5'd16) begin
                              minute_in = FLD_W'({minute_ff, 3'b000} + {minute_ff, 1'b0} + d);
                           end else begin
                              second_in = FLD_W'({second_ff, 3'b000} + {second_ff, 1'b0} + d);
                           end
                        end
                     end
                  end
               end
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_hour_in   = out_hour_ff;
      out_minute_in = out_minute_ff;
      out_second_in = out_second_ff;
      if (load) begin
         out_valid_in  = 1'b1;
         out_kind_in   = kind;
         out_year_in   = (kind == EV_SET) ? year_ff   : '0;
         out_month_in  = (kind == EV_SET) ? month_ff  : '0;
         out_day_in    = (kind == EV_SET) ? day_ff    : '0;
         out_hour_in   = (kind == EV_SET) ? hour_ff   : '0;
         out_minute_in = (kind == EV_SET) ? minute_ff : '0;
         out_second_in = (kind == EV_SET) ? second_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         lead_ff      <= 1'b1;
         pos_ff       <= '0;
         flags_ff     <= 3'b111;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ended_ff     <= ended_in;
         lead_ff      <= lead_in;
         pos_ff       <= pos_in;
         flags_ff     <= flags_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_year       = out_year_ff;
   assign rsp_month      = out_month_ff;
   assign rsp_day        = out_day_ff;
   assign rsp_hour       = out_hour_ff;
   assign rsp_minute     = out_minute_ff;
   assign rsp_second     = out_second_ff;

endmodule

`default_nettype wire

// ----- sv/rtcp_checker.sv -----
// Port-level checks for the serial RTC command parser, and the bind that
// attaches them to the top level. Depends on rtcp_pkg.
`default_nettype none

module rtcp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [rtcp_pkg::KIND_W-1:0]     rsp_event_kind,
   input  wire logic [rtcp_pkg::YEAR_W-1:0]     rsp_year,
   input  wire logic [rtcp_pkg::FLD_W-1:0]      rsp_month,
   input  wire logic [rtcp_pkg::FLD_W-1:0]      rsp_day,
   input  wire logic [rtcp_pkg::FLD_W-1:0]      rsp_hour,
   input  wire logic [rtcp_pkg::FLD_W-1:0]      rsp_minute,
   input  wire logic [rtcp_pkg::FLD_W-1:0]      rsp_second
);
   import rtcp_pkg::*;

   // No result transaction may be pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind <= EV_TOO_LONG))
      else $error("illegal event kind");

   // Only a set request carries timestamp fields.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_SET) |->
         (rsp_year == '0) && (rsp_month == '0) && (rsp_day == '0) &&
         (rsp_hour == '0) && (rsp_minute == '0) && (rsp_second == '0))
      else $error("timestamp fields set on non-set event");

endmodule

bind serial_rtc_command_parser rtcp_checker u_rtcp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_kind (rsp_event_kind),
   .rsp_year       (rsp_year),
   .rsp_month      (rsp_month),
   .rsp_day        (rsp_day),
   .rsp_hour       (rsp_hour),
   .rsp_minute     (rsp_minute),
   .rsp_second     (rsp_second)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serial_rtc_command_parser: streams command lines
// byte by byte, predicts each event in a behavioral model and checks every field.
// Depends only on rtcp_pkg and the parser RTL.

module testbench;
   import rtcp_pkg::*;

   localparam int LINE_MAX      = 96;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [55:0] GET_WORD = "rtc get";
   localparam logic [55:0] SET_WORD = "rtc set";

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [YEAR_W-1:0] year;
      logic [FLD_W-1:0]  month;
      logic [FLD_W-1:0]  day;
      logic [FLD_W-1:0]  hour;
      logic [FLD_W-1:0]  minute;
      logic [FLD_W-1:0]  second;
   } rtc_event_type;

   typedef enum int {DIGITS_RANDOM, DIGITS_ZERO, DIGITS_NINE} digit_style_type;
   typedef enum int {
      MANGLE_BYTE, MANGLE_CUT, MANGLE_TAIL, MANGLE_NUL, MANGLE_LOOKALIKE
   } mangle_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_stall   = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   logic [KIND_W-1:0] rsp_event_kind;
   logic [YEAR_W-1:0] rsp_year;
   logic [FLD_W-1:0] rsp_month;
   logic [FLD_W-1:0] rsp_day;
   logic [FLD_W-1:0] rsp_hour;
   logic [FLD_W-1:0] rsp_minute;
   logic [FLD_W-1:0] rsp_second;

   serial_rtc_command_parser #(.LINE_BUFFER_SIZE(LINE_MAX)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_year       (rsp_year),
      .rsp_month      (rsp_month),
      .rsp_day        (rsp_day),
      .rsp_hour       (rsp_hour),
      .rsp_minute     (rsp_minute),
      .rsp_second     (rsp_second)
   );

   // Line state of the behavioral parser.
   int                line_bytes;
   bit                line_full_hit;
   bit                text_done;
   bit                lead_blank;
   int                match_pos;
   bit                get_ok;
   bit                set_ok;
   bit                date_ok;
   logic [YEAR_W-1:0] year_sum;
   logic [FLD_W-1:0]  month_sum;
   logic [FLD_W-1:0]  day_sum;
   logic [FLD_W-1:0]  hour_sum;
   logic [FLD_W-1:0]  minute_sum;
   logic [FLD_W-1:0]  second_sum;

   rtc_event_type   expected_events[$];
   logic [7:0]      line_buf[$];
   int              errors = 0;
   int              bytes_sent = 0;
   int              quiet_cycles = 0;
   bit              sender_idle_on = 1'b0;
   bit              rsp_idle_on = 1'b0;
   bit              hold_request = 1'b0;
   digit_style_type digit_style = DIGITS_RANDOM;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void restart_line();
      line_bytes    = 0;
      line_full_hit = 1'b0;
      text_done     = 1'b0;
      lead_blank    = 1'b1;
      match_pos     = 0;
      get_ok        = 1'b1;
      set_ok        = 1'b1;
      date_ok       = 1'b1;
      year_sum      = '0;
      month_sum     = '0;
      day_sum       = '0;
      hour_sum      = '0;
      minute_sum    = '0;
      second_sum    = '0;
   endfunction

   // q is the index within "YYYY-MM-DD?HH:MM:SS".
   function automatic void take_date_char(input int q, input logic [7:0] c);
      bit is_digit;
      int d;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d = c - CH_ZERO;
      if (q == 4 || q == 7) begin
         if (c != CH_DASH) date_ok = 1'b0;
      end else if (q == 10) begin
         if (c != CH_SPACE && c != CH_T) date_ok = 1'b0;
      end else if (q == 13 || q == 16) begin
         if (c != CH_COLON) date_ok = 1'b0;
      end else if (!is_digit) begin
         date_ok = 1'b0;
      end else if (q < 4) begin
         year_sum = YEAR_W'(year_sum * 10 + d);
      end else if (q < 7) begin
         month_sum = FLD_W'(month_sum * 10 + d);
      end else if (q < 10) begin
         day_sum = FLD_W'(day_sum * 10 + d);
      end else if (q < 13) begin
         hour_sum = FLD_W'(hour_sum * 10 + d);
      end else if (q < 16) begin
         minute_sum = FLD_W'(minute_sum * 10 + d);
      end else begin
         second_sum = FLD_W'(second_sum * 10 + d);
      end
   endfunction

   function automatic void take_text_char(input logic [7:0] c);
      if (lead_blank) begin
         if (c == CH_SPACE) return;
         lead_blank = 1'b0;
      end
      if (match_pos < POS_SPACES) begin
         if (c != GET_WORD[8*(6-match_pos) +: 8]) get_ok = 1'b0;
         if (c != SET_WORD[8*(6-match_pos) +: 8]) set_ok = 1'b0;
         match_pos++;
         return;
      end
      get_ok = 1'b0;
      if (!set_ok) return;
      if (match_pos == POS_SPACES) begin
         if (c == CH_SPACE) return;
         match_pos = POS_PAYLOAD;
      end
      if (match_pos >= POS_END) begin
         date_ok   = 1'b0;
         match_pos = POS_OVER;
         return;
      end
      take_date_char(match_pos - POS_PAYLOAD, c);
      match_pos++;
   endfunction

   // Advances the line state by one accepted byte; a terminator of a
   // non-empty line queues the event it should produce.
   function automatic void absorb_byte(input logic [7:0] c);
      rtc_event_type ev;
      if (c != CH_CR && c != CH_LF) begin
         if (line_bytes < LINE_MAX - 1) begin
            line_bytes++;
            if (c == CH_NUL) text_done = 1'b1;
            if (!text_done) take_text_char(c);
         end else begin
            line_full_hit = 1'b1;
         end
         return;
      end
      if (!line_full_hit && line_bytes == 0) begin
         restart_line();
         return;
      end
      ev = '0;
      if (line_full_hit) begin
         ev.kind = EV_TOO_LONG;
      end else if (match_pos == POS_SPACES && get_ok) begin
         ev.kind = EV_READ;
      end else if (match_pos >= POS_SPACES && set_ok) begin
         if (date_ok && match_pos == POS_END) begin
            ev.kind   = EV_SET;
            ev.year   = year_sum;
            ev.month  = month_sum;
            ev.day    = day_sum;
            ev.hour   = hour_sum;
            ev.minute = minute_sum;
            ev.second = second_sum;
         end else begin
            ev.kind = EV_USAGE;
         end
      end else begin
         ev.kind = EV_UNKNOWN;
      end
      expected_events.push_back(ev);
      restart_line();
   endfunction

   function automatic void check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : check_results
      rtc_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected event, expected none, actual kind %0d",
                     $time, rsp_event_kind);
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("year", want.year, rsp_year);
            check_field("month", want.month, rsp_month);
            check_field("day", want.day, rsp_day);
            check_field("hour", want.hour, rsp_hour);
            check_field("minute", want.minute, rsp_minute);
            check_field("second", want.second, rsp_second);
         end
      end
   end

   // Result-side back-pressure: random bursts, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] c);
      if (sender_idle_on && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_byte(c);
      bytes_sent++;
   endtask

   task automatic send_buffer();
      while (line_buf.size() != 0) send_byte(line_buf.pop_front());
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic send_line(input string s, input logic [7:0] term);
      put_text(s);
      line_buf.push_back(term);
      send_buffer();
   endtask

   task automatic put_digits(input int n);
      repeat (n) begin
         case (digit_style)
            DIGITS_ZERO: line_buf.push_back(CH_ZERO);
            DIGITS_NINE: line_buf.push_back(CH_NINE);
            default: line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         endcase
      end
   endtask

   task automatic put_noise(input int n, input bit allow_term);
      logic [7:0] c;
      repeat (n) begin
         c = 8'($urandom_range(0, 255));
         if (!allow_term && (c == CH_CR || c == CH_LF)) c = "a";
         line_buf.push_back(c);
      end
   endtask

   task automatic put_spaces(input int most);
      repeat ($urandom_range(0, most)) line_buf.push_back(CH_SPACE);
   endtask

   task automatic build_set_line();
      put_spaces(2);
      put_text("rtc set");
      put_spaces(3);
      put_digits(4);
      line_buf.push_back(CH_DASH);
      put_digits(2);
      line_buf.push_back(CH_DASH);
      put_digits(2);
      line_buf.push_back($urandom_range(0, 1) ? CH_T : CH_SPACE);
      put_digits(2);
      line_buf.push_back(CH_COLON);
      put_digits(2);
      line_buf.push_back(CH_COLON);
      put_digits(2);
   endtask

   task automatic build_get_line();
      put_spaces(3);
      put_text("rtc get");
   endtask

   // Damages a well-formed line in one of several ways.
   task automatic mangle_line();
      int         pos;
      mangle_type how;
      if (line_buf.size() == 0) return;
      pos = $urandom_range(0, line_buf.size() - 1);
      how = mangle_type'($urandom_range(0, 4));
      case (how)
         MANGLE_BYTE: line_buf[pos] = 8'($urandom_range(0, 255));
         MANGLE_CUT: begin
            repeat ($urandom_range(1, 6))
               if (line_buf.size() != 0) line_buf.delete(line_buf.size() - 1);
         end
         MANGLE_TAIL: put_noise($urandom_range(1, 3), 1'b0);
         MANGLE_NUL: line_buf.insert(pos, CH_NUL);
         default: begin
            case ($urandom_range(0, 5))
               0: line_buf[pos] = CH_SPACE;
               1: line_buf[pos] = CH_DASH;
               2: line_buf[pos] = CH_COLON;
               3: line_buf[pos] = CH_T;
               4: line_buf[pos] = CH_ZERO;
               default: line_buf[pos] = CH_NINE;
            endcase
         end
      endcase
   endtask

   task automatic put_term();
      case ($urandom_range(0, 3))
         0: line_buf.push_back(CH_CR);
         1: line_buf.push_back(CH_LF);
         2: begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
         end
         default: begin
            line_buf.push_back(CH_LF);
            line_buf.push_back(CH_LF);
         end
      endcase
   endtask

   task automatic send_random_line();
      int pick;
      int cut;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
         digit_style = $urandom_range(0, 1) ? DIGITS_ZERO : DIGITS_NINE;
      else
         digit_style = DIGITS_RANDOM;
      if (pick < 45) begin
         build_set_line();
      end else if (pick < 65) begin
         build_get_line();
      end else if (pick < 86) begin
         put_noise($urandom_range(0, 24), 1'b1);
      end else if (pick < 94) begin
         // A fragment of one of the two command words.
         cut = $urandom_range(1, 7);
         for (int i = 0; i < cut; i++)
            line_buf.push_back(pick[0] ? GET_WORD[8*(6-i) +: 8] : SET_WORD[8*(6-i) +: 8]);
      end else begin
         if (pick[0]) build_set_line();
         put_noise($urandom_range(LINE_MAX - 4, LINE_MAX + 4) - line_buf.size(), 1'b0);
      end
      if (pick < 65 && $urandom_range(0, 2) == 0) mangle_line();
      put_term();
      send_buffer();
   endtask

   task automatic run_random_lines(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_line();
   endtask

   // The sender goes quiet until every predicted event has been delivered.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
      send_line("rtc get", CH_CR);
      send_line("rtc set 2024-01-15 12:30:45", CH_LF);
      send_line("   rtc get", CH_LF);
      send_line("rtc set    9999-99-99T99:99:99", CH_CR);
      send_line("rtc set 0000-00-00 00:00:00", CH_LF);
      send_line("rtc set2000-02-29T23:59:59", CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_line("rtc set", CH_LF);
      send_line("rtc set   ", CH_LF);
      send_line("rtc set 2024-01-15 12:30:4", CH_LF);
      send_line("rtc set 2024-01-15 12:30:456", CH_LF);
      send_line("rtc set 2024/01-15 12:30:45", CH_CR);
      send_line("rtc set 2a24-01-15 12:30:45", CH_CR);
      send_line("rtc set 2024-01-15_12:30:45", CH_CR);
      send_line("rtc setX", CH_CR);
      send_line("rtc gets", CH_LF);
      send_line("rtc ge", CH_LF);
      send_line("RTC GET", CH_LF);
      send_line("    ", CH_LF);
      // A zero byte first leaves blank text; after a command it hides the tail.
      send_byte(CH_NUL);
      send_line("rtc get", CH_LF);
      put_text("rtc get");
      line_buf.push_back(CH_NUL);
      send_line("junk", CH_LF);
      put_text("rtc set 2024-01-15 12:30:45");
      line_buf.push_back(8'hff);
      line_buf.push_back(CH_CR);
      send_buffer();
      // Longest line that still fits, then one byte more, then far too long.
      repeat (LINE_MAX - 1) line_buf.push_back("a");
      send_line("", CH_LF);
      repeat (LINE_MAX) line_buf.push_back("a");
      send_line("", CH_LF);
      put_text("rtc get");
      repeat (200) line_buf.push_back(CH_SPACE);
      send_line("", CH_CR);
   endtask

   task automatic test_random_traffic();
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
      run_random_lines(300);
   endtask

   // The result side holds off while bytes keep coming, so the input backs up.
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      hold_request   = 1'b1;
      run_random_lines(160);
   endtask

   task automatic test_full_rate();
      sender_idle_on = 1'b0;
      rsp_idle_on    = 1'b0;
      run_random_lines(100);
   endtask

   initial begin
      restart_line();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random_traffic();
      wait_drained();
      test_backpressure();
      wait_drained();
      test_full_rate();
      wait_drained();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
